>>> hdl/oaht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants of the open-addressing hash table
// Slot tag codes, operation codes, the fixed field widths and the load limit reset value.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // fixed field widths and the load limit reset value
   localparam int HASH_BITS   = 32;
   localparam int LIMIT_BITS  = 10;
   localparam int LIMIT_RESET = 768;

   // slot state as kept in the table memory
   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_FULL  = 2'd1,
      TAG_TOMB  = 2'd2
   } tag_type;

   // operation codes of the request word
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_GET    = 2'd2
   } kind_type;

endpackage : oaht_pkg
`default_nettype wire

>>> hdl/open_addressing_hash_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top: linear-probing key/value table
// Add, remove and get on a fixed table of SLOTS slots with tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table memory to empty, one slot a cycle, and
// stalls requests until the sweep is done; CSR writes are taken during the
// sweep. One request is worked at a time. An add, remove or get steps through
// accept, table read, one cycle per probed slot and result handover when SLOTS
// is a power of two; for other sizes the start slot comes out of a reciprocal
// multiply, a quotient-times-size multiply and a fold step before the table
// read. Each probed slot waits on the registered read of the single table
// memory. An add refused by the load limit and an unused opcode go straight
// from acceptance to the result handover. A finished result sits in the
// output register until it is taken while the core returns to idle.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
   parameter int SLOTS      = 1024,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // request channel
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  [1:0]                             req_kind,
   input  wire  [KEY_BITS-1:0]                    req_key_id,
   input  wire  [oaht_pkg::HASH_BITS-1:0]         req_key_hash,
   input  wire  [VALUE_BITS-1:0]                  req_value_in,
   // response channel
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic                                   rsp_ok,
   output logic                                   rsp_refused,
   output logic [VALUE_BITS-1:0]                  rsp_value_out,
   // load limit register
   input  wire                                    csr_we,
   input  wire  [oaht_pkg::LIMIT_BITS-1:0]        csr_wdata
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = ((CNT_W > oaht_pkg::LIMIT_BITS) ? CNT_W : oaht_pkg::LIMIT_BITS) + 1;
   localparam bit POW2   = ((SLOTS & (SLOTS - 1)) == 0);
   localparam int PROD_W = 2 * oaht_pkg::HASH_BITS;
   localparam int QSHIFT = oaht_pkg::HASH_BITS - 1 + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_R  = (IDX_W + 1)'(SLOTS);
   // floor(2^QSHIFT / SLOTS); the quotient estimate is low by at most one
   localparam logic [PROD_W-1:0] RECIP_WIDE = (PROD_W'(1) << QSHIFT) / PROD_W'(SLOTS);
   localparam logic [oaht_pkg::HASH_BITS-1:0] RECIP =
      RECIP_WIDE[oaht_pkg::HASH_BITS-1:0];

   typedef struct packed {
      oaht_pkg::tag_type       tag;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_MULQ,
      ST_FOLD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // registers
   state_type                        state_ff,      state_in;
   logic [IDX_W-1:0]                 clr_ff,        clr_in;
   logic [1:0]                       kind_ff,       kind_in;
   logic [KEY_BITS-1:0]              key_ff,        key_in;
   logic [VALUE_BITS-1:0]            val_ff,        val_in;
   logic [oaht_pkg::HASH_BITS-1:0]   hash_ff,       hash_in;
   logic [PROD_W-1:0]                prod_ff,       prod_in;
   logic [IDX_W:0]                   qd_ff,         qd_in;
   logic [IDX_W-1:0]                 idx_ff,        idx_in;
   logic [IDX_W-1:0]                 cnt_ff,        cnt_in;
   logic                             tomb_seen_ff,  tomb_seen_in;
   logic [IDX_W-1:0]                 tomb_idx_ff,   tomb_idx_in;
   logic [CNT_W-1:0]                 used_ff,       used_in;
   logic [oaht_pkg::LIMIT_BITS-1:0]  limit_ff,      limit_in;
   logic                             res_ok_ff,     res_ok_in;
   logic                             res_ref_ff,    res_ref_in;
   logic [VALUE_BITS-1:0]            res_val_ff,    res_val_in;
   logic                             rsp_valid_ff,  rsp_valid_in;
   logic                             rsp_ok_ff,     rsp_ok_in;
   logic                             rsp_ref_ff,    rsp_ref_in;
   logic [VALUE_BITS-1:0]            rsp_val_ff,    rsp_val_in;

   // table memory ports
   slot_type                         mem [SLOTS];
   slot_type                         rd_data_ff;
   logic [IDX_W-1:0]                 rd_addr;
   logic                             mem_we;
   logic [IDX_W-1:0]                 mem_waddr;
   slot_type                         mem_wdata;

   // start slot helpers
   logic [IDX_W:0]                   q_low;
   logic [IDX_W:0]                   fold_diff;
   logic [IDX_W:0]                   fold_rem;

   // probe evaluation helpers
   logic [IDX_W-1:0]                 idx_nx;
   logic                             load_over;
   logic                             is_empty;
   logic                             is_tomb;
   logic                             is_hit;
   logic                             is_last;
   logic                             ft_seen;
   logic [IDX_W-1:0]                 ft_idx;
   logic                             fresh;

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_refused   = rsp_ref_ff;
   assign rsp_value_out = rsp_val_ff;

   // load check: used + 1 > limit
   assign load_over = ((CMP_W'(used_ff) + CMP_W'(1)) > CMP_W'(limit_ff));

   // hash - q * SLOTS in IDX_W + 1 bits, then one correction
   assign q_low = prod_ff[QSHIFT +: IDX_W + 1];
   always_comb begin
      fold_diff = hash_ff[IDX_W:0] - qd_ff;
      fold_rem  = fold_diff;
      if (fold_diff >= SLOTS_R) begin
         fold_rem = fold_diff - SLOTS_R;
      end
   end

   // slot classification of the word just read
   assign idx_nx   = (idx_ff == LAST_IDX) ? '0 : (idx_ff + IDX_W'(1));
   assign is_empty = (rd_data_ff.tag == oaht_pkg::TAG_EMPTY);
   assign is_tomb  = (rd_data_ff.tag == oaht_pkg::TAG_TOMB);
   assign is_hit   = (rd_data_ff.tag == oaht_pkg::TAG_FULL) && (rd_data_ff.key == key_ff);
   assign is_last  = (cnt_ff == LAST_IDX);
   assign ft_seen  = tomb_seen_ff || is_tomb;
   assign ft_idx   = tomb_seen_ff ? tomb_idx_ff : idx_ff;
   assign fresh    = is_empty && !tomb_seen_ff;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      prod_in      = prod_ff;
      qd_in        = qd_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_idx_in  = tomb_idx_ff;
      used_in      = used_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      res_ok_in    = res_ok_ff;
      res_ref_in   = res_ref_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ref_in   = rsp_ref_ff;
      rsp_val_in   = rsp_val_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{tag: oaht_pkg::TAG_FULL, key: key_ff, value: val_ff};

      // output word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // sweep the table to empty after reset
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '{tag: oaht_pkg::TAG_EMPTY, key: '0, value: '0};
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end

         // take a request word
         ST_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind;
               key_in       = req_key_id;
               val_in       = req_value_in;
               hash_in      = req_key_hash;
               cnt_in       = '0;
               tomb_seen_in = 1'b0;
               res_ok_in    = 1'b0;
               res_ref_in   = 1'b0;
               res_val_in   = '0;
               if (req_kind == oaht_pkg::KIND_ADD && load_over) begin
                  res_ref_in = 1'b1;
                  state_in   = ST_DONE;
               end else if (req_kind != oaht_pkg::KIND_ADD &&
                            req_kind != oaht_pkg::KIND_REMOVE &&
                            req_kind != oaht_pkg::KIND_GET) begin
                  state_in = ST_DONE;
               end else if (POW2) begin
                  idx_in   = req_key_hash[IDX_W-1:0];
                  state_in = ST_READ;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end

         // quotient estimate from the reciprocal
         ST_MUL: begin
            prod_in  = PROD_W'(hash_ff) * PROD_W'(RECIP);
            state_in = ST_MULQ;
         end

         // low bits of quotient times table size
         ST_MULQ: begin
            qd_in    = q_low * SLOTS_R;
            state_in = ST_FOLD;
         end

         // start slot from the corrected remainder
         ST_FOLD: begin
            idx_in   = fold_rem[IDX_W-1:0];
            state_in = ST_READ;
         end

         // first slot read in flight
         ST_READ: begin
            state_in = ST_CHECK;
         end

         // one probed slot per cycle
         ST_CHECK: begin
            if (is_empty || is_hit || is_last) begin
               state_in = ST_DONE;
               case (kind_ff)
                  oaht_pkg::KIND_ADD: begin
                     if (is_hit) begin
                        mem_we = 1'b1;
                     end else if (is_empty || ft_seen) begin
                        mem_we    = 1'b1;
                        mem_waddr = ft_idx;
                        res_ok_in = 1'b1;
                        if (fresh) begin
                           used_in = used_ff + CNT_W'(1);
                        end
                     end else begin
                        res_ref_in = 1'b1;
                     end
                  end
                  oaht_pkg::KIND_REMOVE: begin
                     if (is_hit) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{tag: oaht_pkg::TAG_TOMB, key: rd_data_ff.key,
                                      value: rd_data_ff.value};
                        res_ok_in = 1'b1;
                     end
                  end
                  oaht_pkg::KIND_GET: begin
                     if (is_hit) begin
                        res_ok_in  = 1'b1;
                        res_val_in = rd_data_ff.value;
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               // keep walking; remember the first tombstone
               if (is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in  = idx_ff;
               end
               idx_in = idx_nx;
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_ref_in   = res_ref_ff;
               rsp_val_in   = res_val_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read the slot that idx holds next cycle
   assign rd_addr = idx_in;

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         tomb_seen_ff <= 1'b0;
         used_ff      <= '0;
         limit_ff     <= oaht_pkg::LIMIT_BITS'(oaht_pkg::LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tomb_seen_ff <= tomb_seen_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      hash_ff     <= hash_in;
      prod_ff     <= prod_in;
      qd_ff       <= qd_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      tomb_idx_ff <= tomb_idx_in;
      res_ok_ff   <= res_ok_in;
      res_ref_ff  <= res_ref_in;
      res_val_ff  <= res_val_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_ref_ff  <= rsp_ref_in;
      rsp_val_ff  <= rsp_val_in;
   end

`ifndef SYNTHESIS
   // the used count never falls
   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> used_ff >= $past(used_ff))
      else $error("used count decreased");

   // the used count stays within the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(SLOTS) >= used_ff)
      else $error("used count beyond table size");

   // a new output word only comes from the handover state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside handover");

   // success and refusal are exclusive
   a_ok_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ok_ff && rsp_ref_ff))
      else $error("response both ok and refused");

   // a value is returned only with success
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_val_ff == '0)
      else $error("value returned without success");
`endif

endmodule : open_addressing_hash_table_top
`default_nettype wire
